/* rtl/core/assert_macros.svh */
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FSE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FSE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/fse_pkg.sv */
// types and constants of the fitness selection engine
package fse_pkg;

    localparam int REQ_W   = 2;
    localparam int IDX_W   = 6;
    localparam int FIT_W   = 10;
    localparam int POINT_W = 31;
    localparam int TOTAL_W = 16;
    localparam int CUM_W   = TOTAL_W + 1;
    localparam int PICK_N  = 2 ** IDX_W;

    // remainder unit: one dividend bit per step
    localparam int MOD_STEPS = POINT_W;
    localparam int MOD_CNT_W = $clog2(MOD_STEPS);

    localparam logic [REQ_W-1:0] REQ_WRITE      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ROULETTE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TOURNAMENT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SCAN       = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [IDX_W-1:0]   entry_index;
        logic [FIT_W-1:0]   fitness_value;
        logic [POINT_W-1:0] random_point;
        logic [IDX_W-1:0]   pick_a;
        logic [IDX_W-1:0]   pick_b;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]   selected_index;
        logic [TOTAL_W-1:0] total_fitness;
        logic [FIT_W-1:0]   peak_fitness;
        logic [IDX_W-1:0]   worst_index;
        logic [IDX_W-1:0]   best_index;
        logic               best_found;
        logic               zero_total_error;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR,
        ST_DIV,
        ST_WALK,
        ST_TN_A,
        ST_TN_B,
        ST_SCAN
    } state_t;

endpackage

/* rtl/core/fse_ram.sv */
// generic single-port-write ram with registered read
module fse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/fse_mod_unit.sv */
// restoring remainder unit, one dividend bit per cycle
module fse_mod_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         go,
    input  logic [fse_pkg::POINT_W-1:0]  dividend,
    input  logic [fse_pkg::TOTAL_W-1:0]  divisor,
    output logic                         done,
    output logic [fse_pkg::TOTAL_W-1:0]  remainder
);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [fse_pkg::MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [fse_pkg::TOTAL_W-1:0]   rem_reg, rem_next;
    logic [fse_pkg::POINT_W-1:0]   dvd_reg, dvd_next;
    logic [fse_pkg::TOTAL_W-1:0]   dsr_reg, dsr_next;
    logic [fse_pkg::TOTAL_W:0]     trial;
    logic [fse_pkg::TOTAL_W:0]     diff;

    assign trial = {rem_reg, dvd_reg[fse_pkg::POINT_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            dvd_next = dividend;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[fse_pkg::TOTAL_W-1:0];
            end
            else
            begin
                rem_next = trial[fse_pkg::TOTAL_W-1:0];
            end
            dvd_next = {dvd_reg[fse_pkg::POINT_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == fse_pkg::MOD_CNT_W'(fse_pkg::MOD_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/fitness_selection_engine.sv */
// top level: fitness table, running total and selection sequencer
//
//  channel  | handshake            | payload | notes
//  ---------+----------------------+---------+------------------------------
//  request  | start high, busy low | req     | one item per acceptance
//  result   | done, one cycle      | rsp     | exactly one per item
//
// roulette runs 31 remainder steps, then walks one table
// entry per cycle until the cumulative sum passes the point or the last entry is read
// out-of-range writes and roulette on a zero total answer straight from idle
// after reset the table is cleared one entry a cycle, with busy held high
// the single table read port sets the pace of scan and roulette walks
`include "assert_macros.svh"

module fitness_selection_engine #(
    parameter int POP_SIZE    = 64,
    parameter int FITNESS_MAX = 1023
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  fse_pkg::req_t req,
    output logic          done,
    output fse_pkg::rsp_t rsp
);

    localparam int AW = $clog2(POP_SIZE);
    localparam logic [AW-1:0] LAST = AW'(POP_SIZE - 1);

    function automatic logic [fse_pkg::IDX_W-1:0] to_idx(input logic [AW-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[fse_pkg::IDX_W-1:0];
    endfunction

    fse_pkg::state_t state_reg, state_next;

    logic [AW-1:0]               cnt_reg, cnt_next;
    logic [AW-1:0]               addr_reg, addr_next;
    logic [AW-1:0]               pa_reg, pa_next;
    logic [AW-1:0]               pb_reg, pb_next;
    logic [fse_pkg::FIT_W-1:0]   val_reg, val_next;
    logic [fse_pkg::FIT_W-1:0]   fa_reg, fa_next;
    logic [fse_pkg::TOTAL_W-1:0] total_reg, total_next;
    logic [fse_pkg::TOTAL_W-1:0] point_reg, point_next;
    logic [fse_pkg::CUM_W-1:0]   cum_reg, cum_next;
    logic [fse_pkg::FIT_W-1:0]   mx_reg, mx_next;
    logic [fse_pkg::FIT_W-1:0]   low_reg, low_next;
    logic [AW-1:0]               best_reg, best_next;
    logic [AW-1:0]               worst_reg, worst_next;
    logic                        found_reg, found_next;
    logic                        done_reg, done_next;
    fse_pkg::rsp_t               rsp_reg, rsp_next;

    logic                        accept;
    logic                        wr_ok;
    logic [31:0]                 idx_wide;
    logic [AW-1:0]               ent_addr;
    logic [fse_pkg::IDX_W-1:0]   pick_mod [fse_pkg::PICK_N];
    logic [31:0]                 pa_wide, pb_wide;
    logic [AW-1:0]               pa_addr, pb_addr;
    logic [fse_pkg::FIT_W-1:0]   val_sat;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [fse_pkg::FIT_W-1:0]   ram_wdata, rd_data;

    logic                        mod_go, mod_done;
    logic [fse_pkg::TOTAL_W-1:0] mod_rem;

    logic [fse_pkg::CUM_W-1:0]   cum_sum;
    logic                        walk_hit;
    logic                        at_last;
    logic                        low_take, max_take;
    logic [fse_pkg::FIT_W-1:0]   scan_low, scan_mx;
    logic [AW-1:0]               scan_worst, scan_best;
    logic                        scan_found;

    // tournament picks reduced modulo the population, as a constant table
    for (genvar g = 0; g < fse_pkg::PICK_N; g++)
    begin : g_pick_mod
        localparam int PM = g % POP_SIZE;
        assign pick_mod[g] = fse_pkg::IDX_W'(PM);
    end

    assign accept   = start && !busy;
    assign idx_wide = 32'(req.entry_index);
    assign wr_ok    = idx_wide < 32'(POP_SIZE);
    assign ent_addr = idx_wide[AW-1:0];
    assign pa_wide  = 32'(pick_mod[req.pick_a]);
    assign pb_wide  = 32'(pick_mod[req.pick_b]);
    assign pa_addr  = pa_wide[AW-1:0];
    assign pb_addr  = pb_wide[AW-1:0];
    assign val_sat  = (32'(req.fitness_value) > 32'(FITNESS_MAX)) ?
                      fse_pkg::FIT_W'(FITNESS_MAX) : req.fitness_value;

    assign cum_sum  = cum_reg + fse_pkg::CUM_W'(rd_data);
    assign walk_hit = cum_sum > {1'b0, point_reg};
    assign at_last  = cnt_reg == LAST;

    // first entry seeds the minimum
    assign low_take   = (cnt_reg == '0) || (rd_data < low_reg);
    assign max_take   = rd_data > mx_reg;
    assign scan_low   = low_take ? rd_data : low_reg;
    assign scan_worst = low_take ? cnt_reg : worst_reg;
    assign scan_mx    = max_take ? rd_data : mx_reg;
    assign scan_best  = max_take ? cnt_reg : best_reg;
    assign scan_found = max_take || found_reg;

    fse_ram #(
        .WIDTH (fse_pkg::FIT_W),
        .DEPTH (POP_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    fse_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mod_go),
        .dividend  (req.random_point),
        .divisor   (total_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fse_pkg::ST_CLEAR:
            begin
                if (at_last)
                begin
                    state_next = fse_pkg::ST_IDLE;
                end
            end
            fse_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        fse_pkg::REQ_WRITE:
                            state_next = wr_ok ? fse_pkg::ST_WR : fse_pkg::ST_IDLE;
                        fse_pkg::REQ_ROULETTE:
                            state_next = (total_reg == '0) ? fse_pkg::ST_IDLE
                                                           : fse_pkg::ST_DIV;
                        fse_pkg::REQ_TOURNAMENT:
                            state_next = fse_pkg::ST_TN_A;
                        default:
                            state_next = fse_pkg::ST_SCAN;
                    endcase
                end
            end
            fse_pkg::ST_WR:
            begin
                state_next = fse_pkg::ST_IDLE;
            end
            fse_pkg::ST_DIV:
            begin
                if (mod_done)
                begin
                    state_next = fse_pkg::ST_WALK;
                end
            end
            fse_pkg::ST_WALK:
            begin
                if (walk_hit || at_last)
                begin
                    state_next = fse_pkg::ST_IDLE;
                end
            end
            fse_pkg::ST_TN_A:
            begin
                state_next = fse_pkg::ST_TN_B;
            end
            fse_pkg::ST_TN_B:
            begin
                state_next = fse_pkg::ST_IDLE;
            end
            fse_pkg::ST_SCAN:
            begin
                if (at_last)
                begin
                    state_next = fse_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fse_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        val_next   = val_reg;
        fa_next    = fa_reg;
        total_next = total_reg;
        point_next = point_reg;
        cum_next   = cum_reg;
        mx_next    = mx_reg;
        low_next   = low_reg;
        best_next  = best_reg;
        worst_next = worst_reg;
        found_next = found_reg;
        done_next  = 1'b0;
        rsp_next   = '0;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wdata  = val_reg;
        ram_raddr  = cnt_reg;
        mod_go     = 1'b0;
        case (state_reg)
            fse_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg;
                ram_wdata = '0;
                cnt_next  = at_last ? '0 : cnt_reg + 1'b1;
            end
            fse_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        fse_pkg::REQ_WRITE:
                        begin
                            ram_raddr = ent_addr;
                            addr_next = ent_addr;
                            val_next  = val_sat;
                            // out-of-range slot: answer at once, table untouched
                            done_next = !wr_ok;
                        end
                        fse_pkg::REQ_ROULETTE:
                        begin
                            ram_raddr = '0;
                            if (total_reg == '0)
                            begin
                                done_next                 = 1'b1;
                                rsp_next.zero_total_error = 1'b1;
                            end
                            else
                            begin
                                mod_go = 1'b1;
                            end
                        end
                        fse_pkg::REQ_TOURNAMENT:
                        begin
                            ram_raddr = pa_addr;
                            pa_next   = pa_addr;
                            pb_next   = pb_addr;
                        end
                        default:
                        begin
                            ram_raddr  = '0;
                            cnt_next   = '0;
                            mx_next    = '0;
                            found_next = 1'b0;
                            best_next  = '0;
                            worst_next = '0;
                        end
                    endcase
                end
            end
            fse_pkg::ST_WR:
            begin
                // rd_data holds the old entry
                ram_we     = 1'b1;
                total_next = total_reg - fse_pkg::TOTAL_W'(rd_data)
                           + fse_pkg::TOTAL_W'(val_reg);
                done_next  = 1'b1;
            end
            fse_pkg::ST_DIV:
            begin
                // keep entry 0 on the read port for the walk
                ram_raddr = '0;
                if (mod_done)
                begin
                    point_next = mod_rem;
                    cnt_next   = '0;
                    cum_next   = '0;
                end
            end
            fse_pkg::ST_WALK:
            begin
                ram_raddr = cnt_reg + 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                cum_next  = cum_sum;
                if (walk_hit || at_last)
                begin
                    done_next               = 1'b1;
                    rsp_next.selected_index = to_idx(cnt_reg);
                    cnt_next                = '0;
                end
            end
            fse_pkg::ST_TN_A:
            begin
                fa_next   = rd_data;
                ram_raddr = pb_reg;
            end
            fse_pkg::ST_TN_B:
            begin
                done_next               = 1'b1;
                rsp_next.selected_index = (fa_reg >= rd_data) ? to_idx(pa_reg)
                                                              : to_idx(pb_reg);
            end
            fse_pkg::ST_SCAN:
            begin
                ram_raddr  = cnt_reg + 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                low_next   = scan_low;
                worst_next = scan_worst;
                mx_next    = scan_mx;
                best_next  = scan_best;
                found_next = scan_found;
                if (at_last)
                begin
                    done_next             = 1'b1;
                    cnt_next              = '0;
                    rsp_next.peak_fitness = scan_mx;
                    rsp_next.worst_index  = to_idx(scan_worst);
                    rsp_next.best_index   = to_idx(scan_best);
                    rsp_next.best_found   = scan_found;
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
        rsp_next.total_fitness = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fse_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        val_reg   <= val_next;
        fa_reg    <= fa_next;
        point_reg <= point_next;
        cum_reg   <= cum_next;
        mx_reg    <= mx_next;
        low_reg   <= low_next;
        best_reg  <= best_next;
        worst_reg <= worst_next;
        found_reg <= found_next;
        rsp_reg   <= rsp_next;
    end

    assign busy = state_reg != fse_pkg::ST_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `FSE_ASSERT_NXT(a_roulette_divides,
        accept && (req.req_type == fse_pkg::REQ_ROULETTE) && (total_reg != '0),
        state_reg == fse_pkg::ST_DIV, "roulette with nonzero total skipped the divide")
    `FSE_ASSERT_IMP(a_point_below_total, state_reg == fse_pkg::ST_WALK,
        point_reg < total_reg, "roulette point not reduced below the total")
    `FSE_ASSERT_IMP(a_error_zero_total, done && rsp.zero_total_error,
        (rsp.total_fitness == '0) && (rsp.selected_index == '0),
        "zero total error with a nonzero total or index")
    `FSE_ASSERT_IMP(a_mod_done_in_div, mod_done, state_reg == fse_pkg::ST_DIV,
        "remainder finished outside the divide state")

endmodule
